@@ src/gpr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared types and constants of the GPIO port register block.
// ----------------------------------------------------------------------------
package gpr_pkg;

    localparam int unsigned MAX_PINS = 16;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [2:0] REG_CFG_LOW    = 3'd0;
    localparam logic [2:0] REG_CFG_HIGH   = 3'd1;
    localparam logic [2:0] REG_INPUT      = 3'd2;
    localparam logic [2:0] REG_OUTPUT     = 3'd3;
    localparam logic [2:0] REG_SET_RESET  = 3'd4;
    localparam logic [2:0] REG_RESET_ONLY = 3'd5;
    localparam logic [2:0] REG_LOCK       = 3'd6;

    localparam logic [31:0] CFG_RESET = 32'h4444_4444;
    localparam int unsigned KEY_BIT   = 16;

    typedef struct packed {
        logic        op;
        logic [2:0]  sel;
        logic [31:0] wdata;
        logic [15:0] levels;
    } cmd_t;

    typedef struct packed {
        logic [15:0] bits;
        logic        key;
    } lock_status_t;

endpackage

@@ src/gpr_cmd_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpr_cmd_reg
// Input register: captures one bus access per cycle.
// ----------------------------------------------------------------------------
module gpr_cmd_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  gpr_pkg::cmd_t cmd_in,
    output logic          cmd_valid,
    output gpr_pkg::cmd_t cmd
);

    logic          valid_reg;
    gpr_pkg::cmd_t cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= cmd_in;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

@@ src/gpr_lock_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpr_lock_ctrl
// Lock register and key sequence tracker.
// ----------------------------------------------------------------------------
module gpr_lock_ctrl #(
    parameter logic [15:0] PIN_MASK = 16'hFFFF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  gpr_pkg::cmd_t         cmd,
    output gpr_pkg::lock_status_t status
);

    localparam logic [1:0] LK_IDLE  = 2'd0;
    localparam logic [1:0] LK_STEP1 = 2'd1;
    localparam logic [1:0] LK_STEP2 = 2'd2;
    localparam logic [1:0] LK_STEP3 = 2'd3;

    logic [15:0] lock_bits_reg, lock_bits_next;
    logic        lock_key_reg, lock_key_next;
    logic [1:0]  lock_step_reg, lock_step_next;
    logic [15:0] mask_seen_reg, mask_seen_next;

    always_comb
    begin
        logic [15:0] mask;
        logic        key;
        logic        same;
        mask = cmd.wdata[15:0] & PIN_MASK;
        key  = cmd.wdata[gpr_pkg::KEY_BIT];
        same = (mask == mask_seen_reg);
        lock_bits_next = lock_bits_reg;
        lock_key_next  = lock_key_reg;
        lock_step_next = lock_step_reg;
        mask_seen_next = mask_seen_reg;
        if (cmd_valid && (cmd.sel == gpr_pkg::REG_LOCK) && !lock_key_reg)
        begin
            if (cmd.op == gpr_pkg::OP_WRITE)
            begin
                lock_bits_next = mask;
                if ((lock_step_reg == LK_STEP1) && !key && same)
                begin
                    lock_step_next = LK_STEP2;
                end
                else if ((lock_step_reg == LK_STEP2) && key && same)
                begin
                    lock_step_next = LK_STEP3;
                end
                else if (key)
                begin
                    lock_step_next = LK_STEP1;
                    mask_seen_next = mask;
                end
                else
                begin
                    lock_step_next = LK_IDLE;
                end
            end
            else
            begin
                if (lock_step_reg == LK_STEP3)
                begin
                    lock_key_next = 1'b1;
                end
                lock_step_next = LK_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_bits_reg <= '0;
            lock_key_reg  <= 1'b0;
            lock_step_reg <= LK_IDLE;
            mask_seen_reg <= '0;
        end
        else
        begin
            lock_bits_reg <= lock_bits_next;
            lock_key_reg  <= lock_key_next;
            lock_step_reg <= lock_step_next;
            mask_seen_reg <= mask_seen_next;
        end
    end

    assign status.bits = lock_bits_reg;
    assign status.key  = lock_key_reg;

endmodule

@@ src/gpr_regfile.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpr_regfile
// Configuration and output data registers, read mux and result register.
// ----------------------------------------------------------------------------
module gpr_regfile #(
    parameter logic [15:0] PIN_MASK = 16'hFFFF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  gpr_pkg::cmd_t         cmd,
    input  gpr_pkg::lock_status_t lock,
    output logic                  done,
    output logic [31:0]           read_data,
    output logic [15:0]           out_data
);

    logic [31:0] cfg_low_reg, cfg_low_next;
    logic [31:0] cfg_high_reg, cfg_high_next;
    logic [15:0] out_data_reg, out_data_next;
    logic [31:0] rdata_reg, rdata_next;
    logic        done_reg;

    always_comb
    begin
        logic [15:0] wr_ok;
        logic [31:0] m_lo;
        logic [31:0] m_hi;
        wr_ok = PIN_MASK & ~({16{lock.key}} & lock.bits);
        for (int i = 0; i < 8; i++)
        begin
            m_lo[4*i +: 4] = {4{wr_ok[i]}};
            m_hi[4*i +: 4] = {4{wr_ok[i+8]}};
        end
        cfg_low_next  = cfg_low_reg;
        cfg_high_next = cfg_high_reg;
        out_data_next = out_data_reg;
        rdata_next    = '0;
        if (cmd_valid && (cmd.op == gpr_pkg::OP_WRITE))
        begin
            case (cmd.sel)
                gpr_pkg::REG_CFG_LOW:
                    cfg_low_next = (cfg_low_reg & ~m_lo) | (cmd.wdata & m_lo);
                gpr_pkg::REG_CFG_HIGH:
                    cfg_high_next = (cfg_high_reg & ~m_hi) | (cmd.wdata & m_hi);
                gpr_pkg::REG_OUTPUT:
                    out_data_next = cmd.wdata[15:0] & PIN_MASK;
                gpr_pkg::REG_SET_RESET:
                    out_data_next = ((out_data_reg & ~cmd.wdata[31:16])
                                     | cmd.wdata[15:0]) & PIN_MASK;
                gpr_pkg::REG_RESET_ONLY:
                    out_data_next = out_data_reg & ~cmd.wdata[15:0] & PIN_MASK;
                default:
                    out_data_next = out_data_reg;
            endcase
        end
        else if (cmd_valid)
        begin
            case (cmd.sel)
                gpr_pkg::REG_CFG_LOW:  rdata_next = cfg_low_reg;
                gpr_pkg::REG_CFG_HIGH: rdata_next = cfg_high_reg;
                gpr_pkg::REG_INPUT:    rdata_next = {16'd0, cmd.levels & PIN_MASK};
                gpr_pkg::REG_OUTPUT:   rdata_next = {16'd0, out_data_reg};
                gpr_pkg::REG_LOCK:     rdata_next = {15'd0, lock.key, lock.bits};
                default:               rdata_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_low_reg  <= gpr_pkg::CFG_RESET;
            cfg_high_reg <= gpr_pkg::CFG_RESET;
            out_data_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            cfg_low_reg  <= cfg_low_next;
            cfg_high_reg <= cfg_high_next;
            out_data_reg <= out_data_next;
            done_reg     <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid)
        begin
            rdata_reg <= rdata_next;
        end
    end

    assign done      = done_reg;
    assign read_data = rdata_reg;
    assign out_data  = out_data_reg;

endmodule

@@ src/gpio_port_register_block.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_port_register_block
// 16-pin GPIO port register file with configuration lock.
//
// one bus access is an item: operation, reg_select, write_data and the
// sampled pin_levels, taken at a clock edge where start is high and busy low
// busy stays low, so a new access can be issued in every cycle
// the access is registered, executed in the next cycle, and its result
// (read_data, pin_drive, lock_active) shows for one cycle with done high,
// from the execute-stage registers, and is taken by the receiver at the
// edge that ends it; throughput one item per cycle, set by the single
// execute stage that updates the registers
// pin_drive and lock_active follow the port state after that item
// the receiver cannot stall, so done is never held
// reset: config words 0x44444444, output data and lock state cleared,
// no item in flight
// ----------------------------------------------------------------------------
module gpio_port_register_block #(
    parameter int unsigned PIN_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [2:0]  reg_select,
    input  logic [31:0] write_data,
    input  logic [15:0] pin_levels,
    output logic        done,
    output logic [31:0] read_data,
    output logic [15:0] pin_drive,
    output logic        lock_active
);

    localparam logic [15:0] PIN_MASK = 16'((32'd1 << PIN_COUNT) - 32'd1);

    gpr_pkg::cmd_t         cmd_in;
    gpr_pkg::cmd_t         cmd;
    logic                  cmd_valid;
    gpr_pkg::lock_status_t lock;

    assign busy = 1'b0;

    assign cmd_in.op     = operation;
    assign cmd_in.sel    = reg_select;
    assign cmd_in.wdata  = write_data;
    assign cmd_in.levels = pin_levels;

    gpr_cmd_reg u_cmd_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (start && !busy),
        .cmd_in    (cmd_in),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    gpr_lock_ctrl #(
        .PIN_MASK (PIN_MASK)
    ) u_lock_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .status    (lock)
    );

    gpr_regfile #(
        .PIN_MASK (PIN_MASK)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .lock      (lock),
        .done      (done),
        .read_data (read_data),
        .out_data  (pin_drive)
    );

    assign lock_active = lock.key;

    // each accepted item yields a result, registered by the command and execute stages
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted item produced no result");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without accepted item");

    // lock holds until reset
    a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        lock_active |=> lock_active)
        else $error("lock released without reset");

    a_absent_pins_low: assert property (@(posedge clk) disable iff (!rst_n)
        (pin_drive & ~PIN_MASK) == 16'd0)
        else $error("drive on absent pin");

endmodule
